// ===== design/dpb_pkg.sv =====
// Shared types, constants and helpers for the depth pixel backprojection unit.
// No dependencies; every other file of the block imports this package.
package dpb_pkg;

  localparam int DEF_MAX_DIM = 4096;
  localparam int Q_BITS      = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int COUNT_W     = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [4:0]  decimation_step;
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
  } cfg_t;

  // per-result data that travels from the front to the back untouched
  typedef struct packed {
    logic               has_point;
    logic               frame_end;
    logic [COUNT_W-1:0] point_count;
    logic [15:0]        depth_mm;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } qmeta_t;

  // width of a signed position minus center difference
  function automatic int diff_width(input int max_dim);
    int idx_w;
    idx_w = $clog2(max_dim);
    return ((idx_w > 12) ? idx_w : 12) + 1;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/dpb_if.sv =====
// Valid/ready channel interfaces: pixel input, point output, register writes.
// Depends on dpb_pkg for field widths.
interface dpb_pixel_if import dpb_pkg::*;;
  logic        valid;
  logic        ready;
  logic [15:0] depth_mm;
  logic        depth_invalid;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  modport source (output valid, depth_mm, depth_invalid, red, green, blue, input ready);
  modport sink   (input valid, depth_mm, depth_invalid, red, green, blue, output ready);
endinterface

interface dpb_point_if import dpb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [31:0]        point_x;
  logic [31:0]        point_y;
  logic [15:0]        point_z;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               has_point;
  logic               frame_end;
  logic [COUNT_W-1:0] point_count;
  modport source (output valid, point_x, point_y, point_z, out_red, out_green, out_blue,
                  has_point, frame_end, point_count, input ready);
  modport sink   (input valid, point_x, point_y, point_z, out_red, out_green, out_blue,
                  has_point, frame_end, point_count, output ready);
endinterface

interface dpb_cfg_if import dpb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/depth_pixel_backprojection_unit.sv =====
// Top level of the depth pixel backprojection unit: register file and wiring.
// Depends on dpb_pkg, dpb_if, dpb_front, dpb_queue and dpb_back.
//
// Usage:
//   pixel : raster-order depth pixels with colour, one word per pixel.
//   point : one word per kept pixel with a valid depth and for the final
//           pixel of every frame (frame_end set, point_count valid).
//   cfg   : register writes, index 0..6 as in dpb_pkg; always ready. Write
//           only while no pixel is in flight.
// Path: a result word reaches point through the queue, two multiply stages
//   and the output register after its pixel is taken.
// Throughput: one pixel per cycle while point is taken, set by the front-end
//   counter update per accepted pixel and the fully pipelined multipliers.
// Stall: when point is not taken the back pipeline freezes; the four-word
//   queue absorbs results, and pixel.ready drops once it is full.
// Reset: registers return to their defaults (640x480, step 1, center 320/240,
//   inverse focal 31957), position and point counters clear; no warm-up.
module depth_pixel_backprojection_unit import dpb_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input logic        clk,
  input logic        rst,
  dpb_pixel_if.sink  pixel,
  dpb_point_if.source point,
  dpb_cfg_if.sink    cfg
);

  localparam int DIFF_W = diff_width(MAX_DIM);
  localparam int QW     = $bits(qmeta_t) + 2 * DIFF_W;

  cfg_t                     regs;
  logic                     push, pop, full, empty;
  qmeta_t                   f_meta, b_meta;
  logic signed [DIFF_W-1:0] f_dx, f_dy, b_dx, b_dy;
  logic [QW-1:0]            q_wr, q_rd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.image_width     <= 13'd640;
      regs.image_height    <= 13'd480;
      regs.decimation_step <= 5'd1;
      regs.center_x        <= 12'd320;
      regs.center_y        <= 12'd240;
      regs.inv_focal_x     <= 24'd31957;
      regs.inv_focal_y     <= 24'd31957;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  regs.image_width     <= cfg.data[12:0];
        REG_IMAGE_HEIGHT: regs.image_height    <= cfg.data[12:0];
        REG_DECIM_STEP:   regs.decimation_step <= cfg.data[4:0];
        REG_CENTER_X:     regs.center_x        <= cfg.data[11:0];
        REG_CENTER_Y:     regs.center_y        <= cfg.data[11:0];
        REG_INV_FOCAL_X:  regs.inv_focal_x     <= cfg.data[23:0];
        REG_INV_FOCAL_Y:  regs.inv_focal_y     <= cfg.data[23:0];
        default:          regs                 <= regs;
      endcase
    end
  end

  dpb_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .cfg   (regs),
    .full  (full),
    .push  (push),
    .meta  (f_meta),
    .dx    (f_dx),
    .dy    (f_dy)
  );

  assign q_wr = {f_meta, f_dx, f_dy};
  assign {b_meta, b_dx, b_dy} = q_rd;

  dpb_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (q_wr),
    .pop     (pop),
    .rd_data (q_rd),
    .full    (full),
    .empty   (empty)
  );

  dpb_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!empty),
    .in_meta     (b_meta),
    .in_dx       (b_dx),
    .in_dy       (b_dy),
    .inv_focal_x (regs.inv_focal_x),
    .inv_focal_y (regs.inv_focal_y),
    .pop         (pop),
    .point       (point)
  );

endmodule

// ===== design/dpb_front.sv =====
// Front end: raster position counters, decimation, point classification.
// Depends on dpb_pkg and dpb_pixel_if; pushes one queue word per result.
module dpb_front import dpb_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int DIM_W  = IDX_W + 1,
  localparam int DIFF_W = diff_width(MAX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst,
  dpb_pixel_if.sink                pixel,
  input  cfg_t                     cfg,
  input  logic                     full,
  output logic                     push,
  output qmeta_t                   meta,
  output logic signed [DIFF_W-1:0] dx,
  output logic signed [DIFF_W-1:0] dy
);

  localparam logic [13:0] MAX_C = 14'(MAX_DIM);

  logic [IDX_W-1:0]   column_index, column_index_next;
  logic [IDX_W-1:0]   row_index, row_index_next;
  logic [3:0]         column_phase, column_phase_next;
  logic [3:0]         row_phase, row_phase_next;
  logic [COUNT_W-1:0] points_in_frame, points_in_frame_next;

  logic [13:0]      w_cl, h_cl;
  logic [DIM_W-1:0] w_m1, h_m1;
  logic [4:0]       step;
  logic             accept, last_col, last_row, frame_end, kept, has_point;

  always_comb begin
    if (cfg.image_width == 13'd0) begin
      w_cl = 14'd1;
    end else if ({1'b0, cfg.image_width} > MAX_C) begin
      w_cl = MAX_C;
    end else begin
      w_cl = {1'b0, cfg.image_width};
    end
    if (cfg.image_height == 13'd0) begin
      h_cl = 14'd1;
    end else if ({1'b0, cfg.image_height} > MAX_C) begin
      h_cl = MAX_C;
    end else begin
      h_cl = {1'b0, cfg.image_height};
    end
    if (cfg.decimation_step == 5'd0) begin
      step = 5'd1;
    end else if (cfg.decimation_step > 5'd16) begin
      step = 5'd16;
    end else begin
      step = cfg.decimation_step;
    end
  end

  assign w_m1      = DIM_W'(w_cl - 14'd1);
  assign h_m1      = DIM_W'(h_cl - 14'd1);
  assign last_col  = DIM_W'(column_index) >= w_m1;
  assign last_row  = DIM_W'(row_index) >= h_m1;
  assign frame_end = last_col && last_row;
  assign kept      = (column_phase == 4'd0) && (row_phase == 4'd0);
  assign has_point = kept && (pixel.depth_mm != 16'd0) && !pixel.depth_invalid;

  assign pixel.ready = !full;
  assign accept      = pixel.valid && pixel.ready;
  assign push        = accept && (has_point || frame_end);

  always_comb begin
    points_in_frame_next = points_in_frame;
    if (has_point && points_in_frame != COUNT_MAX) begin
      points_in_frame_next = points_in_frame + 1'b1;
    end
  end

  always_comb begin
    meta.has_point   = has_point;
    meta.frame_end   = frame_end;
    meta.point_count = points_in_frame_next;
    meta.depth_mm    = has_point ? pixel.depth_mm : 16'd0;
    meta.red         = has_point ? pixel.red : 8'd0;
    meta.green       = has_point ? pixel.green : 8'd0;
    meta.blue        = has_point ? pixel.blue : 8'd0;
    dx = has_point ? $signed(DIFF_W'(column_index)) - $signed(DIFF_W'(cfg.center_x))
                   : '0;
    dy = has_point ? $signed(DIFF_W'(row_index)) - $signed(DIFF_W'(cfg.center_y))
                   : '0;
  end

  always_comb begin
    column_index_next = column_index;
    row_index_next    = row_index;
    column_phase_next = column_phase;
    row_phase_next    = row_phase;
    if (frame_end) begin
      column_index_next = '0;
      row_index_next    = '0;
      column_phase_next = '0;
      row_phase_next    = '0;
    end else if (last_col) begin
      column_index_next = '0;
      column_phase_next = '0;
      row_index_next    = row_index + 1'b1;
      row_phase_next    = ({1'b0, row_phase} + 5'd1 >= step) ? 4'd0 : row_phase + 4'd1;
    end else begin
      column_index_next = column_index + 1'b1;
      column_phase_next = ({1'b0, column_phase} + 5'd1 >= step) ? 4'd0
                                                                : column_phase + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index    <= '0;
      row_index       <= '0;
      column_phase    <= '0;
      row_phase       <= '0;
      points_in_frame <= '0;
    end else if (accept) begin
      column_index    <= column_index_next;
      row_index       <= row_index_next;
      column_phase    <= column_phase_next;
      row_phase       <= row_phase_next;
      points_in_frame <= frame_end ? '0 : points_in_frame_next;
    end
  end

endmodule

// ===== design/dpb_queue.sv =====
// Short FIFO between front and back end, register array with a fill count.
// Depends on dpb_pkg for the default depth.
module dpb_queue import dpb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == FULL_CNT;
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

// ===== design/dpb_back.sv =====
// Back end: two-stage multiply, floor shift and saturation, output register.
// Depends on dpb_pkg and dpb_point_if; the whole pipeline stalls together.
module dpb_back import dpb_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int DIFF_W = diff_width(MAX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  qmeta_t                   in_meta,
  input  logic signed [DIFF_W-1:0] in_dx,
  input  logic signed [DIFF_W-1:0] in_dy,
  input  logic [23:0]              inv_focal_x,
  input  logic [23:0]              inv_focal_y,
  output logic                     pop,
  dpb_point_if.source              point
);

  localparam int P1_W = DIFF_W + 17;
  localparam int P2_W = P1_W + 25;
  localparam int Q_W  = P2_W - Q_BITS;

  logic                   advance;
  logic                   s1_valid, s2_valid;
  qmeta_t                 s1_meta, s2_meta;
  logic signed [P1_W-1:0] s1_px, s1_py;
  logic signed [P2_W-1:0] s2_px, s2_py;
  logic signed [Q_W-1:0]  qx, qy;

  assign advance = !point.valid || point.ready;
  assign pop     = advance && in_valid;

  // arithmetic shift gives the floor for both signs
  assign qx = Q_W'(s2_px >>> Q_BITS);
  assign qy = Q_W'(s2_py >>> Q_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      point.valid <= 1'b0;
    end else if (advance) begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      point.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_meta           <= in_meta;
      s1_px             <= in_dx * $signed({1'b0, in_meta.depth_mm});
      s1_py             <= in_dy * $signed({1'b0, in_meta.depth_mm});
      s2_meta           <= s1_meta;
      s2_px             <= s1_px * $signed({1'b0, inv_focal_x});
      s2_py             <= s1_py * $signed({1'b0, inv_focal_y});
      point.point_x     <= sat32(64'(qx));
      point.point_y     <= sat32(64'(qy));
      point.point_z     <= s2_meta.depth_mm;
      point.out_red     <= s2_meta.red;
      point.out_green   <= s2_meta.green;
      point.out_blue    <= s2_meta.blue;
      point.has_point   <= s2_meta.has_point;
      point.frame_end   <= s2_meta.frame_end;
      point.point_count <= s2_meta.point_count;
    end
  end

endmodule
